### rtl/fcfs_pkg.sv
package fcfs_pkg;

  localparam int SLOTS = 16;
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef logic [IW-1:0] slot_t;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_KILL = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;

  localparam logic [2:0] SOP_NOP     = 3'd0;
  localparam logic [2:0] SOP_ADD     = 3'd1;
  localparam logic [2:0] SOP_RUN     = 3'd2;
  localparam logic [2:0] SOP_IOSTART = 3'd3;
  localparam logic [2:0] SOP_FREE    = 3'd4;
  localparam logic [2:0] SOP_SETRDY  = 3'd5;
  localparam logic [2:0] SOP_SETRUN  = 3'd6;

  typedef struct packed {
    logic [2:0]  op;
    slot_t       idx;
    logic        io_dec;
    logic [15:0] pid;
    logic [15:0] burst;
    logic [15:0] iob;
    logic [15:0] iol;
  } slot_ctrl_t;

  typedef struct packed {
    logic  drop;
    logic  by_slot;
    slot_t pos;
    slot_t key;
    logic  push;
    slot_t push_slot;
  } q_ctrl_t;

endpackage

### rtl/fcfs_qcell.sv
module fcfs_qcell (
  input  logic             clk,
  input  logic             rst_n,
  input  fcfs_pkg::q_ctrl_t ctrl,
  input  logic             hit_pos,
  input  logic             shift_in,
  input  logic             prev_valid,
  input  fcfs_pkg::slot_t  nxt_slot,
  input  logic             nxt_valid,
  output fcfs_pkg::slot_t  slot,
  output logic             valid,
  output logic             shift_out
);

  fcfs_pkg::slot_t slot_r;
  logic            valid_r;
  logic            hit;

  assign hit       = valid_r && (ctrl.by_slot ? (slot_r == ctrl.key) : hit_pos);
  assign shift_out = ctrl.drop && (shift_in || hit);
  assign slot      = slot_r;
  assign valid     = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_out) begin
      valid_r <= nxt_valid;
    end else if (ctrl.push && !valid_r && prev_valid) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_out) begin
      slot_r <= nxt_slot;
    end else if (ctrl.push && !valid_r && prev_valid) begin
      slot_r <= ctrl.push_slot;
    end
  end

endmodule

### rtl/fcfs_queue.sv
module fcfs_queue (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  fcfs_pkg::q_ctrl_t                         ctrl,
  output logic [fcfs_pkg::SLOTS-1:0][fcfs_pkg::IW-1:0] slots,
  output logic [fcfs_pkg::SLOTS-1:0]                 valids
);

  logic [fcfs_pkg::SLOTS:0] shift_c;

  assign shift_c[0] = 1'b0;

  for (genvar i = 0; i < fcfs_pkg::SLOTS; i++) begin : g_cell
    fcfs_pkg::slot_t ns;
    logic            nv;
    logic            pv;
    if (i == fcfs_pkg::SLOTS - 1) begin : g_last
      assign ns = '0;
      assign nv = 1'b0;
    end else begin : g_mid
      assign ns = slots[i+1];
      assign nv = valids[i+1];
    end
    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_rest
      assign pv = valids[i-1];
    end
    fcfs_qcell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .hit_pos    (ctrl.pos == fcfs_pkg::slot_t'(i)),
      .shift_in   (shift_c[i]),
      .prev_valid (pv),
      .nxt_slot   (ns),
      .nxt_valid  (nv),
      .slot       (slots[i]),
      .valid      (valids[i]),
      .shift_out  (shift_c[i+1])
    );
  end

endmodule

### rtl/fcfs_slot.sv
module fcfs_slot (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcfs_pkg::slot_t      my_idx,
  input  fcfs_pkg::slot_ctrl_t ctrl,
  output logic                 used,
  output logic [15:0]          pid,
  output logic [15:0]          burst,
  output logic [15:0]          cpu_left,
  output logic [15:0]          executed,
  output logic [15:0]          io_begin,
  output logic [15:0]          io_length,
  output logic [15:0]          io_left,
  output logic [1:0]           status
);

  logic        used_r;
  logic [15:0] pid_r, burst_r, cpu_r, exec_r, iob_r, iol_r, iolft_r;
  logic [1:0]  st_r;
  logic        sel;

  assign sel       = (ctrl.idx == my_idx);
  assign used      = used_r;
  assign pid       = pid_r;
  assign burst     = burst_r;
  assign cpu_left  = cpu_r;
  assign executed  = exec_r;
  assign io_begin  = iob_r;
  assign io_length = iol_r;
  assign io_left   = iolft_r;
  assign status    = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (sel && ctrl.op == fcfs_pkg::SOP_ADD) begin
      used_r <= 1'b1;
    end else if (sel && ctrl.op == fcfs_pkg::SOP_FREE) begin
      used_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.io_dec && used_r && st_r == fcfs_pkg::ST_WAITING && iolft_r != 16'd0) begin
      iolft_r <= iolft_r - 16'd1;
    end
    if (sel) begin
      case (ctrl.op)
        fcfs_pkg::SOP_ADD: begin
          pid_r   <= ctrl.pid;
          burst_r <= ctrl.burst;
          cpu_r   <= ctrl.burst;
          exec_r  <= 16'd0;
          iob_r   <= ctrl.iob;
          iol_r   <= ctrl.iol;
          iolft_r <= 16'd0;
          st_r    <= fcfs_pkg::ST_READY;
        end
        fcfs_pkg::SOP_RUN: begin
          exec_r <= exec_r + 16'd1;
          if (cpu_r != 16'd0) begin
            cpu_r <= cpu_r - 16'd1;
          end
        end
        fcfs_pkg::SOP_IOSTART: begin
          iolft_r <= iol_r;
          st_r    <= fcfs_pkg::ST_WAITING;
        end
        fcfs_pkg::SOP_SETRDY: st_r <= fcfs_pkg::ST_READY;
        fcfs_pkg::SOP_SETRUN: st_r <= fcfs_pkg::ST_RUNNING;
        default: ;
      endcase
    end
  end

endmodule

### rtl/fcfs_scheduler_with_io_and_kill.sv
// first-come-first-served scheduler, one i/o burst per process
// input channel (in_valid/in_ready): one beat is an add, a kill or a tick
// result channel (out_valid/out_ready): one beat per finished or killed process
// add and kill are taken in the idle state; a tick runs through the dispatch,
// run and check states and then a scan of the waiting queue: the walk down
// the waiting queue cells that returns finished i/o to the
// ready queue one slot per cycle
// a beat that makes a result then passes through a load step for the output
// register; the next input beat is taken right after, even while that result
// still waits for out_ready
// if the receiver stalls and a second result is due, the block holds in that
// load step until the output register frees
// reset (rst_n low, synchronous) empties the table and both queues, clears
// the running process and the tick counter, and drops any pending result
module fcfs_scheduler_with_io_and_kill (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_process_id,
  input  logic [15:0] in_cpu_burst,
  input  logic [15:0] in_io_start,
  input  logic [15:0] in_io_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_done_id,
  output logic [31:0] out_finish_time,
  output logic [31:0] out_wait_ticks,
  output logic        out_was_killed
);

  localparam int SLOTS = fcfs_pkg::SLOTS;
  localparam int CW = fcfs_pkg::CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [31:0]     tick_r, tick_nxt;
  logic            rv_r, rv_nxt;
  fcfs_pkg::slot_t run_r, run_nxt;
  logic [CW-1:0]   p_r, p_nxt;
  logic [15:0]     res_pid_r, res_pid_nxt;
  logic [31:0]     res_ft_r, res_ft_nxt;
  logic [31:0]     res_wt_r, res_wt_nxt;
  logic            res_k_r, res_k_nxt;
  logic            pend_r, pend_nxt;
  logic            ov_r;
  logic [15:0]     od_r;
  logic [31:0]     oft_r, owt_r;
  logic            ok_r;

  fcfs_pkg::slot_ctrl_t sc;
  fcfs_pkg::q_ctrl_t    rq, wq;

  logic [SLOTS-1:0]        used_v;
  logic [SLOTS-1:0][15:0]  pid_v, burst_v, cpu_v, exec_v, iob_v, iol_v, iolft_v;
  logic [SLOTS-1:0][1:0]   st_v;
  logic [SLOTS-1:0][fcfs_pkg::IW-1:0] rq_slots, wq_slots;
  logic [SLOTS-1:0]        rq_valids, wq_valids;

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    fcfs_slot u_slot (
      .clk       (clk),
      .rst_n     (rst_n),
      .my_idx    (fcfs_pkg::slot_t'(i)),
      .ctrl      (sc),
      .used      (used_v[i]),
      .pid       (pid_v[i]),
      .burst     (burst_v[i]),
      .cpu_left  (cpu_v[i]),
      .executed  (exec_v[i]),
      .io_begin  (iob_v[i]),
      .io_length (iol_v[i]),
      .io_left   (iolft_v[i]),
      .status    (st_v[i])
    );
  end

  fcfs_queue u_ready (.clk(clk), .rst_n(rst_n), .ctrl(rq), .slots(rq_slots), .valids(rq_valids));
  fcfs_queue u_wait (.clk(clk), .rst_n(rst_n), .ctrl(wq), .slots(wq_slots), .valids(wq_valids));

  logic            dup, free_ok, k_ok;
  fcfs_pkg::slot_t free_idx, k_idx;

  always_comb begin
    dup      = 1'b0;
    free_ok  = 1'b0;
    free_idx = '0;
    k_ok     = 1'b0;
    k_idx    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (used_v[i] && pid_v[i] == in_process_id) begin
        dup = 1'b1;
        if (!k_ok) begin
          k_ok  = 1'b1;
          k_idx = fcfs_pkg::slot_t'(i);
        end
      end
      if (!used_v[i] && !free_ok) begin
        free_ok  = 1'b1;
        free_idx = fcfs_pkg::slot_t'(i);
      end
    end
  end

  fcfs_pkg::slot_t pidx, wslot;
  logic            pvalid;
  logic [31:0]     ft1;
  logic            load;

  assign pidx   = p_r[fcfs_pkg::IW-1:0];
  assign pvalid = (p_r < CW'(SLOTS)) && wq_valids[pidx];
  assign wslot  = wq_slots[pidx];
  assign ft1    = tick_r + 32'd1;
  assign load   = (state_r == S_EMIT) && (!ov_r || out_ready);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    tick_nxt    = tick_r;
    rv_nxt      = rv_r;
    run_nxt     = run_r;
    p_nxt       = p_r;
    res_pid_nxt = res_pid_r;
    res_ft_nxt  = res_ft_r;
    res_wt_nxt  = res_wt_r;
    res_k_nxt   = res_k_r;
    pend_nxt    = pend_r;
    sc          = '0;
    rq          = '0;
    wq          = '0;
    sc.pid      = in_process_id;
    sc.burst    = in_cpu_burst;
    sc.iob      = in_io_start;
    sc.iol      = in_io_duration;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            fcfs_pkg::ACT_ADD: begin
              if (!dup && free_ok) begin
                sc.op        = fcfs_pkg::SOP_ADD;
                sc.idx       = free_idx;
                rq.push      = 1'b1;
                rq.push_slot = free_idx;
              end
            end
            fcfs_pkg::ACT_KILL: begin
              if (k_ok) begin
                sc.op  = fcfs_pkg::SOP_FREE;
                sc.idx = k_idx;
                if (rv_r && run_r == k_idx) begin
                  rv_nxt = 1'b0;
                end else if (st_v[k_idx] == fcfs_pkg::ST_WAITING) begin
                  wq.drop    = 1'b1;
                  wq.by_slot = 1'b1;
                  wq.key     = k_idx;
                end else begin
                  rq.drop    = 1'b1;
                  rq.by_slot = 1'b1;
                  rq.key     = k_idx;
                end
                res_pid_nxt = in_process_id;
                res_ft_nxt  = tick_r;
                res_wt_nxt  = 32'd0;
                res_k_nxt   = 1'b1;
                state_nxt   = S_EMIT;
              end
            end
            fcfs_pkg::ACT_TICK: begin
              pend_nxt  = 1'b0;
              state_nxt = S_DISP;
            end
            default: ;
          endcase
        end
      end
      S_DISP: begin
        if (!rv_r && rq_valids[0]) begin
          run_nxt = rq_slots[0];
          rv_nxt  = 1'b1;
          rq.drop = 1'b1;
          rq.pos  = '0;
          sc.op   = fcfs_pkg::SOP_SETRUN;
          sc.idx  = rq_slots[0];
        end
        state_nxt = S_RUN;
      end
      S_RUN: begin
        sc.io_dec = 1'b1;
        if (rv_r) begin
          sc.op  = fcfs_pkg::SOP_RUN;
          sc.idx = run_r;
        end
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (rv_r) begin
          if (cpu_v[run_r] != 16'd0 && exec_v[run_r] == iob_v[run_r]
              && iol_v[run_r] != 16'd0) begin
            sc.op        = fcfs_pkg::SOP_IOSTART;
            sc.idx       = run_r;
            wq.push      = 1'b1;
            wq.push_slot = run_r;
            rv_nxt       = 1'b0;
          end else if (cpu_v[run_r] == 16'd0) begin
            sc.op       = fcfs_pkg::SOP_FREE;
            sc.idx      = run_r;
            rv_nxt      = 1'b0;
            res_pid_nxt = pid_v[run_r];
            res_ft_nxt  = ft1;
            res_wt_nxt  = ft1 - {16'd0, burst_v[run_r]};
            res_k_nxt   = 1'b0;
            pend_nxt    = 1'b1;
          end
        end
        p_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pvalid) begin
          if (iolft_v[wslot] == 16'd0) begin
            wq.drop      = 1'b1;
            wq.pos       = pidx;
            rq.push      = 1'b1;
            rq.push_slot = wslot;
            sc.op        = fcfs_pkg::SOP_SETRDY;
            sc.idx       = wslot;
          end else begin
            p_nxt = p_r + CW'(1);
          end
        end else begin
          tick_nxt  = ft1;
          state_nxt = pend_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tick_r  <= '0;
      rv_r    <= 1'b0;
      run_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      rv_r    <= rv_nxt;
      run_r   <= run_nxt;
      pend_r  <= pend_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    res_pid_r <= res_pid_nxt;
    res_ft_r  <= res_ft_nxt;
    res_wt_r  <= res_wt_nxt;
    res_k_r   <= res_k_nxt;
    if (load) begin
      od_r  <= res_pid_r;
      oft_r <= res_ft_r;
      owt_r <= res_wt_r;
      ok_r  <= res_k_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_done_id     = od_r;
  assign out_finish_time = oft_r;
  assign out_wait_ticks  = owt_r;
  assign out_was_killed  = ok_r;

endmodule
